FILE: hw/rtl/lot_min_heap_by_expiry_defines.svh
// Assertion macros shared by the heap RTL.
`ifndef LOT_MIN_HEAP_BY_EXPIRY_DEFINES_SVH
`define LOT_MIN_HEAP_BY_EXPIRY_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LMH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmh same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmh next-cycle check failed");

`endif

FILE: hw/rtl/lmh_pkg.sv
`default_nettype none

package lmh_pkg;

    // Field widths
    localparam int KEY_W  = 31;
    localparam int AMT_W  = 16;
    localparam int SUM_W  = 24;
    localparam int LOTS_W = 9;
    localparam int STAT_W = 2;
    localparam int LOT_W  = KEY_W + AMT_W;

    localparam int DEF_CAPACITY = 256;

    // Key reported when removing from an empty heap
    localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] expiry_time;
        logic [AMT_W-1:0] lot_amount;
    } lmh_in_t;

    typedef struct packed {
        logic [KEY_W-1:0]  out_expiry;
        logic [AMT_W-1:0]  out_amount;
        logic [STAT_W-1:0] status;
        logic [SUM_W-1:0]  amount_total;
        logic [LOTS_W-1:0] lots_held;
    } lmh_out_t;

    // One heap entry as stored in memory
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amt;
    } lot_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lmh_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port.
module lmh_ram #(
    parameter int WIDTH = lmh_pkg::LOT_W,
    parameter int DEPTH = lmh_pkg::DEF_CAPACITY
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lmh_rsp_reg.sv
`default_nettype none

// Output register: holds one finished word until the receiver takes it.
module lmh_rsp_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire lmh_pkg::lmh_out_t load_word,
    output logic                 free,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output lmh_pkg::lmh_out_t    rsp
);

    import lmh_pkg::*;

    logic     valid_reg, valid_next;
    lmh_out_t word_reg, word_next;

    // Slot is free when empty or being drained this cycle
    assign free = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (load)
        begin
            valid_next = 1'b1;
            word_next  = load_word;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign rsp_valid = valid_reg;
    assign rsp       = word_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lot_min_heap_by_expiry.sv
// Min-heap of lots ordered by expiry key, with a running quantity total.
// Request channel (req_valid/req_ready/req): one word per operation, func
// selects insert or remove of the earliest-expiring lot. Response channel
// (rsp_valid/rsp_ready/rsp): exactly one word per request, in order.
// One operation is in flight at a time; req_ready is high while the
// controller is idle, also while a finished word waits in the output
// register, so the next request is taken in the cycle after a load.
// Insert: the new lot starts in the first free slot and climbs; each level
// takes one parent read and one compare-write, and a lot that reaches the
// root is written there without a read. Remove: the root is read and
// returned, then the last lot is read and sinks from the root; each level
// takes a read of the left child, a read of the right child when it exists,
// and one compare-write. A remove that empties the heap skips the descent.
// A full insert or an empty remove goes straight to the response.
// When the receiver stalls, a second finished word waits in the controller
// until the output register frees. Reset empties the heap (count and total
// cleared); the RAM is not cleared, as only filled slots are ever read.
`default_nettype none

`include "lot_min_heap_by_expiry_defines.svh"

module lot_min_heap_by_expiry #(
    parameter int CAPACITY = lmh_pkg::DEF_CAPACITY
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire lmh_pkg::lmh_in_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output lmh_pkg::lmh_out_t  rsp
);

    import lmh_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CH_W  = IDX_W + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_RD   = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_RM_ROOT = 4'd3;
    localparam logic [3:0] S_RM_LAST = 4'd4;
    localparam logic [3:0] S_DN_L    = 4'd5;
    localparam logic [3:0] S_DN_R    = 4'd6;
    localparam logic [3:0] S_DN_C    = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_count_reg, fill_count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    lot_t              mov_reg, mov_next;
    lot_t              lft_reg, lft_next;
    logic              r_ok_reg, r_ok_next;
    logic [KEY_W-1:0]  res_key_reg, res_key_next;
    logic [AMT_W-1:0]  res_amt_reg, res_amt_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;

    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    lot_t              wr_data;
    logic [LOT_W-1:0]  rd_raw;
    lot_t              rd_data;

    logic              accept;
    logic              rsp_free, rsp_load;
    lmh_out_t          rsp_word;

    logic [IDX_W-1:0]  parent;
    logic [CH_W-1:0]   child_l, child_r, fill_ext;
    logic              l_ok, r_ok;
    logic              take_l, take_r;
    logic [KEY_W-1:0]  best_key;

    assign rd_data = lot_t'(rd_raw);
    assign accept  = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);

    // Heap index arithmetic
    assign parent   = (pos_reg - IDX_W'(1)) >> 1;
    assign child_l  = {1'b0, pos_reg, 1'b1};
    assign child_r  = child_l + CH_W'(1);
    assign fill_ext = CH_W'(fill_count_reg);
    assign l_ok     = child_l < fill_ext;
    assign r_ok     = child_r < fill_ext;

    // Child selection: strictly smaller keys only; on equal keys the left child wins
    assign take_l   = lft_reg.key < mov_reg.key;
    assign best_key = take_l ? lft_reg.key : mov_reg.key;
    assign take_r   = r_ok_reg && (rd_data.key < best_key);

    // Controller
    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        sum_next        = sum_reg;
        pos_next        = pos_reg;
        mov_next        = mov_reg;
        lft_next        = lft_reg;
        r_ok_next       = r_ok_reg;
        res_key_next    = res_key_reg;
        res_amt_next    = res_amt_reg;
        res_stat_next   = res_stat_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = mov_reg;
        rsp_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_key_next  = '0;
                    res_amt_next  = '0;
                    res_stat_next = STAT_DONE;
                    if (req.func == FUNC_INSERT)
                    begin
                        if (fill_count_reg >= CNT_W'(CAPACITY))
                        begin
                            res_stat_next = STAT_FULL;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            mov_next.key    = req.expiry_time;
                            mov_next.amt    = req.lot_amount;
                            pos_next        = fill_count_reg[IDX_W-1:0];
                            fill_count_next = fill_count_reg + CNT_W'(1);
                            sum_next        = sum_reg + SUM_W'(req.lot_amount);
                            state_next      = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (fill_count_reg == '0)
                        begin
                            res_key_next  = EMPTY_KEY;
                            res_stat_next = STAT_EMPTY;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            // fetch the root
                            rd_en           = 1'b1;
                            rd_addr         = '0;
                            fill_count_next = fill_count_reg - CNT_W'(1);
                            state_next      = S_RM_ROOT;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data.key > mov_reg.key)
                begin
                    // parent moves down into the hole
                    wr_data    = rd_data;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_RM_ROOT:
            begin
                res_key_next = rd_data.key;
                res_amt_next = rd_data.amt;
                sum_next     = sum_reg - SUM_W'(rd_data.amt);
                if (fill_count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // fetch the last lot
                    rd_en      = 1'b1;
                    rd_addr    = fill_count_reg[IDX_W-1:0];
                    state_next = S_RM_LAST;
                end
            end

            S_RM_LAST:
            begin
                mov_next   = rd_data;
                pos_next   = '0;
                state_next = S_DN_L;
            end

            S_DN_L:
            begin
                if (l_ok)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = child_l[IDX_W-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DN_R:
            begin
                lft_next  = rd_data;
                r_ok_next = r_ok;
                if (r_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = child_r[IDX_W-1:0];
                end
                state_next = S_DN_C;
            end

            S_DN_C:
            begin
                wr_en = 1'b1;
                if (take_r)
                begin
                    wr_data    = rd_data;
                    pos_next   = child_r[IDX_W-1:0];
                    state_next = S_DN_L;
                end
                else if (take_l)
                begin
                    wr_data    = lft_reg;
                    pos_next   = child_l[IDX_W-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            sum_reg        <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        mov_reg      <= mov_next;
        lft_reg      <= lft_next;
        r_ok_reg     <= r_ok_next;
        res_key_reg  <= res_key_next;
        res_amt_reg  <= res_amt_next;
        res_stat_reg <= res_stat_next;
    end

    // Response word
    always_comb
    begin
        rsp_word.out_expiry   = res_key_reg;
        rsp_word.out_amount   = res_amt_reg;
        rsp_word.status       = res_stat_reg;
        rsp_word.amount_total = sum_reg;
        rsp_word.lots_held    = LOTS_W'(fill_count_reg);
    end

    lmh_ram #(
        .WIDTH (LOT_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (LOT_W'(wr_data)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    lmh_rsp_reg u_rsp_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rsp_load),
        .load_word (rsp_word),
        .free      (rsp_free),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Checks
    `LMH_ASSERT_NOW(a_fill_bound, 1'b1, fill_count_reg <= CNT_W'(CAPACITY))
    `LMH_ASSERT_NEXT(a_accept_starts_work, accept, state_reg != S_IDLE)
    `LMH_ASSERT_NOW(a_no_write_idle, wr_en, state_reg != S_IDLE && state_reg != S_DONE)
    `LMH_ASSERT_NOW(a_full_means_capacity, rsp_valid && rsp.status == STAT_FULL,
        rsp.lots_held == LOTS_W'(CAPACITY))

endmodule

`default_nettype wire
